// ----- rtl/assert_macros.svh -----
// Assertion helpers for the matrix builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, cond, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ----- rtl/ewm_pkg.sv -----
package ewm_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int CORDIC_STEPS = 30;
  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] row_index;
    logic signed [31:0] elem_x;
    logic signed [31:0] elem_y;
    logic signed [31:0] elem_z;
    logic last_row;
  } out_beat_t;

  // Arctangent of 2^-i, 2^32 steps per turn.
  function automatic logic signed [33:0] atan_phase(input logic [4:0] i);
    unique case (i)
      5'd0: return 34'sd536870912;  5'd1: return 34'sd316933406;
      5'd2: return 34'sd167458907;  5'd3: return 34'sd85004756;
      5'd4: return 34'sd42667331;   5'd5: return 34'sd21354465;
      5'd6: return 34'sd10679838;   5'd7: return 34'sd5340245;
      5'd8: return 34'sd2670163;    5'd9: return 34'sd1335087;
      5'd10: return 34'sd667544;    5'd11: return 34'sd333772;
      5'd12: return 34'sd166886;    5'd13: return 34'sd83443;
      5'd14: return 34'sd41722;     5'd15: return 34'sd20861;
      5'd16: return 34'sd10430;     5'd17: return 34'sd5215;
      5'd18: return 34'sd2608;      5'd19: return 34'sd1304;
      5'd20: return 34'sd652;       5'd21: return 34'sd326;
      5'd22: return 34'sd163;       5'd23: return 34'sd81;
      5'd24: return 34'sd41;        5'd25: return 34'sd20;
      5'd26: return 34'sd10;        5'd27: return 34'sd5;
      5'd28: return 34'sd3;         5'd29: return 34'sd1;
      default: return 34'sd0;
    endcase
  endfunction

  // Round a Q1.30 value to Q1.F and clamp to plus or minus one.
  function automatic logic signed [TW-1:0] trig_round(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [34:0] one;
    t = (35'(v) + (35'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    one = 35'sd1 <<< TRIG_FRAC_BITS;
    if (t > one) return TW'(one);
    if (t < -one) return TW'(-one);
    return TW'(t);
  endfunction
endpackage

// ----- rtl/ewm_stream_if.sv -----
interface ewm_stream_if #(type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/ewm_cordic.sv -----
// Pipelined CORDIC for three angles at once, one rotation step per stage.
// The whole pipe advances on en; the side payload travels alongside in euler_world_matrix.
module ewm_cordic import ewm_pkg::*; (
  input  logic clk,
  input  logic en,
  input  logic [2:0][15:0] angle,
  output logic [2:0][TW-1:0] cos_o,
  output logic [2:0][TW-1:0] sin_o
);
  logic signed [33:0] x [CORDIC_STEPS+1][3];
  logic signed [33:0] y [CORDIC_STEPS+1][3];
  logic signed [33:0] z [CORDIC_STEPS+1][3];
  logic [1:0] q [CORDIC_STEPS+1][3];

  // Quadrant split of the phase.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        logic [31:0] ph;
        logic [1:0] qq;
        ph = {angle[a], 16'd0} & ({32{1'b1}} << (32 - ANGLE_BITS));
        qq = 2'((ph + 32'h2000_0000) >> 30);
        q[0][a] <= qq;
        x[0][a] <= CORDIC_GAIN;
        y[0][a] <= '0;
        z[0][a] <= 34'(signed'(ph - {qq, 30'd0}));
      end
    end
  end

  // Rotation steps.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        for (int a = 0; a < 3; a++) begin
          q[i+1][a] <= q[i][a];
          if (!z[i][a][33]) begin
            x[i+1][a] <= x[i][a] - (y[i][a] >>> i);
            y[i+1][a] <= y[i][a] + (x[i][a] >>> i);
            z[i+1][a] <= z[i][a] - atan_phase(5'(i));
          end else begin
            x[i+1][a] <= x[i][a] + (y[i][a] >>> i);
            y[i+1][a] <= y[i][a] - (x[i][a] >>> i);
            z[i+1][a] <= z[i][a] + atan_phase(5'(i));
          end
        end
      end
    end
  end

  // Quadrant fold and rounding to Q1.F.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [33:0] cx, sy;
        cx = x[CORDIC_STEPS][a];
        sy = y[CORDIC_STEPS][a];
        unique case (q[CORDIC_STEPS][a])
          2'd0: begin cos_o[a] <= trig_round(cx); sin_o[a] <= trig_round(sy); end
          2'd1: begin cos_o[a] <= trig_round(-sy); sin_o[a] <= trig_round(cx); end
          2'd2: begin cos_o[a] <= trig_round(-cx); sin_o[a] <= trig_round(-sy); end
          default: begin cos_o[a] <= trig_round(sy); sin_o[a] <= trig_round(-cx); end
        endcase
      end
    end
  end
endmodule

// ----- rtl/euler_world_matrix.sv -----
// Builds a scaled Euler XYZ world matrix. Each accepted beat yields four
// output beats: rows right, up, look (last_row low) and the position row
// (last_row high), in that order. Beats are taken while the pipeline has
// room; once an item waits in its last stage, the single output channel,
// which carries one row per cycle while ready is high, sets the pace. The
// next item is loaded in the same cycle that the last row of the previous
// one leaves. The first row is presented from the row register, after a
// 32-stage CORDIC (quadrant split, 30 rotations, fold), two matrix product
// stages and a scale stage. While rows wait on the output, the pipeline
// holds, except that empty slots at its end still move up.
`include "assert_macros.svh"
module euler_world_matrix import ewm_pkg::*; (
  input logic clk,
  input logic rst,
  ewm_stream_if.sink in_ch,
  ewm_stream_if.source out_ch
);
  localparam int DEPTH = CORDIC_STEPS + 5;
  localparam int F = TRIG_FRAC_BITS;
  localparam int PW = 2 * TW + 2;

  logic en;
  logic [DEPTH-1:0] vld;
  in_beat_t pay [DEPTH];
  logic [2:0][15:0] ang;
  logic [2:0][TW-1:0] cs, sn;
  logic signed [TW-1:0] a_m [3][3];
  logic signed [TW-1:0] m_m [3][3];
  logic signed [31:0] el [3][3];
  in_beat_t hold;
  logic [2:0] rows_left;
  logic [1:0] row;

  // Pipeline advances when the row serializer is free, when its last stage
  // is empty, or when the final row of the current item leaves this cycle.
  assign en = (rows_left == 3'd0) || !vld[DEPTH-1] ||
              (rows_left == 3'd1 && out_ch.ready);
  assign in_ch.ready = en && !rst;
  assign ang = {in_ch.data.angle_z, in_ch.data.angle_y, in_ch.data.angle_x};

  ewm_cordic u_cordic (.clk, .en, .angle(ang), .cos_o(cs), .sin_o(sn));

  // Side payload and valid bits travel with the CORDIC.
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], in_ch.valid};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pay[0] <= in_ch.data;
      for (int i = 1; i < DEPTH; i++) pay[i] <= pay[i-1];
    end
  end

  function automatic logic signed [TW-1:0] rnd(input logic signed [PW-1:0] v);
    return TW'((v + (PW'(1) <<< (F - 1))) >>> F);
  endfunction

  // Stage: A = Rx*Ry (sparse, at most one product per element).
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [TW-1:0] cx, sx, cy, sy;
      cx = cs[0]; sx = sn[0]; cy = cs[1]; sy = sn[1];
      a_m[0][0] <= cy; a_m[0][1] <= '0; a_m[0][2] <= -sy;
      a_m[1][0] <= rnd(PW'(sx) * PW'(sy));
      a_m[1][1] <= cx;
      a_m[1][2] <= rnd(PW'(sx) * PW'(cy));
      a_m[2][0] <= rnd(PW'(cx) * PW'(sy));
      a_m[2][1] <= -sx;
      a_m[2][2] <= rnd(PW'(cx) * PW'(cy));
    end
  end

  // Stage: M = A*Rz; z cosine and sine are delayed one stage to line up.
  logic signed [TW-1:0] cz_d, sz_d;
  always_ff @(posedge clk) begin
    if (en) begin
      cz_d <= cs[2];
      sz_d <= sn[2];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_m[i][0] <= rnd(PW'(a_m[i][0]) * PW'(cz_d) - PW'(a_m[i][1]) * PW'(sz_d));
        m_m[i][1] <= rnd(PW'(a_m[i][0]) * PW'(sz_d) + PW'(a_m[i][1]) * PW'(cz_d));
        m_m[i][2] <= a_m[i][2];
      end
    end
  end

  // Stage: scale and saturate to Q16.16.
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [15:0] sc [3];
      logic signed [47:0] p;
      sc[0] = pay[DEPTH-2].scale_x;
      sc[1] = pay[DEPTH-2].scale_y;
      sc[2] = pay[DEPTH-2].scale_z;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          p = (48'(m_m[i][j]) * 48'(sc[i]) + (48'sd1 <<< (F - 9))) >>> (F - 8);
          if (p > 48'sh7FFF_FFFF) el[i][j] <= 32'sh7FFF_FFFF;
          else if (p < -48'sh8000_0000) el[i][j] <= 32'sh8000_0000;
          else el[i][j] <= 32'(p);
        end
    end
  end

  // Row serializer: four output beats per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_left <= '0;
      row <= '0;
    end else if (en && vld[DEPTH-1]) begin
      rows_left <= 3'd4;
      row <= '0;
    end else if (rows_left != 3'd0 && out_ch.ready) begin
      rows_left <= rows_left - 3'd1;
      row <= row + 2'd1;
    end
  end
  logic signed [31:0] el_h [3][3];
  always_ff @(posedge clk) begin
    if (en && vld[DEPTH-1]) begin
      hold <= pay[DEPTH-1];
      el_h <= el;
    end
  end

  assign out_ch.valid = (rows_left != 3'd0);
  always_comb begin
    out_ch.data.row_index = row;
    out_ch.data.last_row = (row == 2'd3);
    if (row == 2'd3) begin
      out_ch.data.elem_x = hold.pos_x;
      out_ch.data.elem_y = hold.pos_y;
      out_ch.data.elem_z = hold.pos_z;
    end else begin
      out_ch.data.elem_x = el_h[row][0];
      out_ch.data.elem_y = el_h[row][1];
      out_ch.data.elem_z = el_h[row][2];
    end
  end

  `ASSERT_IMPL(a_rows_bound, rows_left <= 3'd4, "row count out of range")
  `ASSERT_NEXT(a_load, en && vld[DEPTH-1], rows_left == 3'd4 && row == 2'd0, "row load missed")
  `ASSERT_IMPL(a_last, !(out_ch.valid && out_ch.data.last_row) || rows_left == 3'd1, "last row misplaced")
endmodule
